### rtl/core/qba_pkg.sv
// Package with the constants, types and helper functions of the quadtree buddy allocator.
`timescale 1ns / 1ps

package qba_pkg;

    localparam int MAX_SIDE_LOG2 = 12;
    localparam int MAX_PAGES     = 16;
    localparam int FREE_DEPTH    = 4;

    localparam int NUM_LEVELS = MAX_SIDE_LOG2 + 1;
    localparam int LOG2_W     = 4;
    localparam int REQ_W      = 13;
    localparam int COORD_W    = 12;
    localparam int PAGE_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 4;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int HEAD_W     = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int ADDR_W     = $clog2(NUM_LEVELS * FREE_DEPTH);
    localparam int MEM_DEPTH  = NUM_LEVELS * FREE_DEPTH;
    localparam int PAGES_W    = $clog2(MAX_PAGES + 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERSIZE = 2'd1,
        STATUS_NO_PAGES = 2'd2
    } status_t;

    typedef enum logic {
        CFG_MAX_SIZE = 1'b0,
        CFG_MIN_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEARCH,
        ST_READ,
        ST_SPLIT,
        ST_PUSH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } quad_t;

    // Clamps a configured log2 size to the largest supported side.
    function automatic logic [LOG2_W-1:0] clamp_log2(input logic [CFG_W-1:0] v);
        logic [LOG2_W-1:0] r;
        if (32'(v) > MAX_SIDE_LOG2) begin
            r = LOG2_W'(MAX_SIDE_LOG2);
        end else begin
            r = LOG2_W'(v);
        end
        return r;
    endfunction

    // Smallest n with 2^n >= v; zero and one both give zero.
    function automatic logic [LOG2_W-1:0] ceil_log2(input logic [REQ_W-1:0] v);
        logic [REQ_W-1:0]  m;
        logic [LOG2_W-1:0] n;
        m = v - REQ_W'(1);
        n = '0;
        if (v > REQ_W'(1)) begin
            for (int i = 0; i < REQ_W; i++) begin
                if (m[i]) begin
                    n = LOG2_W'(i + 1);
                end
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/qba_if.sv
// Valid/ready channel interfaces for allocation requests and grants.
`timescale 1ns / 1ps

interface qba_req_if;
    import qba_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;

    modport source (output valid, output req_width, output req_height, input ready);
    modport sink (input valid, input req_width, input req_height, output ready);
endinterface

interface qba_grant_if;
    import qba_pkg::*;

    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   grant_page;
    logic [COORD_W-1:0]  grant_x;
    logic [COORD_W-1:0]  grant_y;
    logic [LOG2_W-1:0]   grant_size_log2;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, output grant_page, output grant_x, output grant_y,
        output grant_size_log2, output status, input ready
    );
    modport sink (
        input valid, input grant_page, input grant_x, input grant_y,
        input grant_size_log2, input status, output ready
    );
endinterface

### rtl/core/quadtree_buddy_allocator.sv
// Top level of the quadtree buddy allocator: sequencer, free-list memory and level bookkeeping.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake        Item contents
//  cfg       in         cfg_we           cfg_index selects the register, cfg_data is its value
//  req       in         valid / ready    req_width, req_height
//  grant     out        valid / ready    grant_page, grant_x, grant_y, grant_size_log2, status
//
// A request is first sized, then the free lists are examined in turn (up to NUM_LEVELS),
// then the popped entry is read, or a fresh page is opened when every list is empty; each
// level split is one check plus one push for each of three children, and a final check
// precedes offering the grant. An oversize request takes the shortest path. The free-list
// memory, accessed once per cycle, and the one-child-per-cycle push shape this sequence.
// Reset clears the level counts, read pointers and page count at once; the free-list
// memory itself is not cleared, since an entry is only read once its level holds it.
// A grant waiting on a stalled sink holds; a new request is taken in the cycle the grant
// leaves.

module quadtree_buddy_allocator (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  qba_pkg::cfg_index_t   cfg_index,
    input  logic [qba_pkg::CFG_W-1:0] cfg_data,
    qba_req_if.sink               req,
    qba_grant_if.source           grant
);
    import qba_pkg::*;

    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(FREE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(FREE_DEPTH);

    // Configuration registers.
    logic [CFG_W-1:0] max_size_reg;
    logic [CFG_W-1:0] min_size_reg;

    // Sequencer state and working registers.
    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    width_reg, width_next;
    logic [REQ_W-1:0]    height_reg, height_next;
    logic [LOG2_W-1:0]   s_reg, s_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [LOG2_W-1:0]   cur_reg, cur_next;
    logic [1:0]          child_reg, child_next;
    quad_t               quad_reg, quad_next;
    status_t             status_reg, status_next;
    logic [PAGES_W-1:0]  pages_used_reg, pages_used_next;

    // Per-level bookkeeping, all touched at the current level only.
    logic [CNT_W-1:0]  free_count_reg [NUM_LEVELS];
    logic [HEAD_W-1:0] free_head_reg [NUM_LEVELS];
    logic              pop_en;
    logic              push_en;

    // Free-list memory, one row of FREE_DEPTH slots per level.
    quad_t             free_mem [MEM_DEPTH];
    quad_t             rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    quad_t             wr_data;

    logic [LOG2_W-1:0]  maxl;
    logic [LOG2_W-1:0]  minl;
    logic [LOG2_W-1:0]  sw;
    logic [LOG2_W-1:0]  sh;
    logic [LOG2_W-1:0]  s_calc;
    logic [CNT_W-1:0]   cur_count;
    logic [HEAD_W-1:0]  cur_head;
    logic [HEAD_W-1:0]  head_inc;
    logic [CNT_W:0]     slot_sum;
    logic [CNT_W:0]     slot_wrap;
    logic [COORD_W-1:0] half;
    logic               req_take;

    assign maxl      = clamp_log2(max_size_reg);
    assign minl      = clamp_log2(min_size_reg);
    assign sw        = ceil_log2(width_reg);
    assign sh        = ceil_log2(height_reg);
    assign cur_count = free_count_reg[lvl_reg];
    assign cur_head  = free_head_reg[lvl_reg];
    assign head_inc  = (32'(cur_head) == FREE_DEPTH - 1) ? '0 : cur_head + HEAD_W'(1);
    // Tail slot: head plus count stays below twice the depth, so one subtract wraps it.
    assign slot_sum  = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_count);
    assign slot_wrap = (slot_sum >= (CNT_W + 1)'(FREE_DEPTH))
                     ? slot_sum - (CNT_W + 1)'(FREE_DEPTH) : slot_sum;
    assign half      = COORD_W'(1) << cur_reg;
    assign rd_addr   = ADDR_W'(lvl_reg) * DEPTH_A + ADDR_W'(cur_head);
    assign wr_addr   = ADDR_W'(lvl_reg) * DEPTH_A + ADDR_W'(slot_wrap);

    always_comb
    begin
        s_calc = sw;
        if (sh > s_calc) begin
            s_calc = sh;
        end
        if (minl > s_calc) begin
            s_calc = minl;
        end
    end

    assign req.ready = (state_reg == ST_IDLE) || ((state_reg == ST_OUT) && grant.ready);
    assign req_take  = req.valid && req.ready;

    assign grant.valid           = (state_reg == ST_OUT);
    assign grant.grant_page      = quad_reg.page;
    assign grant.grant_x         = quad_reg.x;
    assign grant.grant_y         = quad_reg.y;
    assign grant.grant_size_log2 = (status_reg == STATUS_OK) ? s_reg : '0;
    assign grant.status          = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_size_reg <= CFG_W'(MAX_SIDE_LOG2);
            min_size_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_SIZE: max_size_reg <= cfg_data;
                CFG_MIN_SIZE: min_size_reg <= cfg_data;
                default:      max_size_reg <= max_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            pages_used_reg <= '0;
        end else begin
            state_reg      <= state_next;
            pages_used_reg <= pages_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        height_reg <= height_next;
        s_reg      <= s_next;
        lvl_reg    <= lvl_next;
        cur_reg    <= cur_next;
        child_reg  <= child_next;
        quad_reg   <= quad_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                free_count_reg[i] <= '0;
                free_head_reg[i]  <= '0;
            end
        end else if (pop_en) begin
            free_count_reg[lvl_reg] <= cur_count - CNT_W'(1);
            free_head_reg[lvl_reg]  <= head_inc;
        end else if (push_en) begin
            free_count_reg[lvl_reg] <= cur_count + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            free_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= free_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        s_next          = s_reg;
        lvl_next        = lvl_reg;
        cur_next        = cur_reg;
        child_next      = child_reg;
        quad_next       = quad_reg;
        status_next     = status_reg;
        pages_used_next = pages_used_reg;
        pop_en          = 1'b0;
        push_en         = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = quad_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_take) begin
                    width_next  = req.req_width;
                    height_next = req.req_height;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC: begin
                s_next = s_calc;
                if (s_calc > maxl) begin
                    status_next = STATUS_OVERSIZE;
                    quad_next   = '0;
                    state_next  = ST_OUT;
                end else begin
                    lvl_next   = LVL_W'(maxl - s_calc);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (cur_count != '0) begin
                    pop_en     = 1'b1;
                    rd_en      = 1'b1;
                    state_next = ST_READ;
                end else if (lvl_reg != '0) begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end else if (32'(pages_used_reg) >= MAX_PAGES) begin
                    status_next = STATUS_NO_PAGES;
                    quad_next   = '0;
                    state_next  = ST_OUT;
                end else begin
                    // Every list is empty: open a fresh page as one whole quad.
                    quad_next.page  = PAGE_W'(pages_used_reg);
                    quad_next.x     = '0;
                    quad_next.y     = '0;
                    pages_used_next = pages_used_reg + PAGES_W'(1);
                    cur_next        = maxl;
                    state_next      = ST_SPLIT;
                end
            end
            ST_READ: begin
                quad_next  = rd_data_reg;
                cur_next   = maxl - LOG2_W'(lvl_reg);
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (cur_reg > s_reg) begin
                    cur_next   = cur_reg - LOG2_W'(1);
                    lvl_next   = lvl_reg + LVL_W'(1);
                    child_next = 2'd0;
                    state_next = ST_PUSH;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = ST_OUT;
                end
            end
            ST_PUSH: begin
                // Right, bottom and bottom-right quadrants go to the finer level in turn;
                // a push into a full list is dropped.
                case (child_reg)
                    2'd0:    wr_data.x = quad_reg.x + half;
                    2'd1:    wr_data.y = quad_reg.y + half;
                    default: begin
                        wr_data.x = quad_reg.x + half;
                        wr_data.y = quad_reg.y + half;
                    end
                endcase
                if (cur_count < DEPTH_C) begin
                    wr_en   = 1'b1;
                    push_en = 1'b1;
                end
                if (child_reg == 2'd2) begin
                    state_next = ST_SPLIT;
                end else begin
                    child_next = child_reg + 2'd1;
                end
            end
            ST_OUT: begin
                if (grant.ready) begin
                    if (req_take) begin
                        width_next  = req.req_width;
                        height_next = req.req_height;
                        state_next  = ST_CALC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
